// ===== rtl/ddrf_pkg.sv =====
`default_nettype none

package ddrf_pkg;

  localparam int DepthDef       = 16;
  localparam int CmdBitsDef     = 8;
  localparam int PayloadBitsDef = 32;

  typedef enum logic [1:0] {
    FUNC_PUSH = 2'd0,
    FUNC_PEEK = 2'd1,
    FUNC_POP  = 2'd2,
    FUNC_NOP  = 2'd3
  } ddrf_func_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } ddrf_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PUSH,
    S_SKIP,
    S_HEAD,
    S_EMPTY,
    S_NOP
  } ddrf_state_e;

  typedef struct packed {
    logic         capture;
    logic         scan_start;
    logic         scan_run;
    logic         skip_adv;
    logic         head_rd;
    logic         push_wr;
    logic         pop_adv;
    logic         emit;
    ddrf_status_e res;
    logic         res_head;
  } ddrf_cmd_t;

  typedef struct packed {
    ddrf_func_e func;
    logic       scan_done;
    logic       empty;
    logic       full;
    logic       head_valid;
    logic       out_free;
  } ddrf_stat_t;

endpackage

`default_nettype wire

// ===== rtl/ddrf_if.sv =====
`default_nettype none

interface ddrf_in_if #(
  parameter int CMD_BITS     = ddrf_pkg::CmdBitsDef,
  parameter int PAYLOAD_BITS = ddrf_pkg::PayloadBitsDef
);
  logic                    valid;
  logic                    ready;
  logic [1:0]              func;
  logic [CMD_BITS-1:0]     cmd_id;
  logic [PAYLOAD_BITS-1:0] payload;

  modport source (output valid, func, cmd_id, payload, input ready);
  modport sink   (input valid, func, cmd_id, payload, output ready);
endinterface

interface ddrf_out_if #(
  parameter int CMD_BITS     = ddrf_pkg::CmdBitsDef,
  parameter int PAYLOAD_BITS = ddrf_pkg::PayloadBitsDef
);
  logic                    valid;
  logic                    ready;
  logic [1:0]              status;
  logic [CMD_BITS-1:0]     head_cmd;
  logic [PAYLOAD_BITS-1:0] head_payload;

  modport source (output valid, status, head_cmd, head_payload, input ready);
  modport sink   (input valid, status, head_cmd, head_payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/ddrf_datapath.sv =====
`default_nettype none

module ddrf_datapath #(
  parameter int DEPTH        = ddrf_pkg::DepthDef,
  parameter int CMD_BITS     = ddrf_pkg::CmdBitsDef,
  parameter int PAYLOAD_BITS = ddrf_pkg::PayloadBitsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ddrf_pkg::ddrf_func_e     in_func_i,
  input  logic [CMD_BITS-1:0]      in_cmd_id_i,
  input  logic [PAYLOAD_BITS-1:0]  in_payload_i,
  input  ddrf_pkg::ddrf_cmd_t      cmd_i,
  output ddrf_pkg::ddrf_stat_t     stat_o,
  input  logic                     out_ready_i,
  output logic                     out_valid_o,
  output logic [1:0]               out_status_o,
  output logic [CMD_BITS-1:0]      out_head_cmd_o,
  output logic [PAYLOAD_BITS-1:0]  out_head_payload_o
);
  import ddrf_pkg::*;

  localparam int PtrW = $clog2(DEPTH);

  function automatic logic [PtrW-1:0] nxt_slot(input logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  logic [PtrW-1:0]         rp_q, wp_q, scan_q, chk_ptr_q, rd_addr;
  logic                    chk_q, rd_en, scan_issue, out_free, match;
  logic [DEPTH-1:0]        valid_q;
  ddrf_func_e              func_q;
  logic [CMD_BITS-1:0]     cmd_q, rd_cmd_q;
  logic [PAYLOAD_BITS-1:0] pay_q, rd_data_q;
  logic [CMD_BITS-1:0]     cmd_mem [DEPTH];
  logic [PAYLOAD_BITS-1:0] data_mem [DEPTH];
  logic                    out_valid_q;
  logic [1:0]              out_status_q;
  logic [CMD_BITS-1:0]     out_cmd_q;
  logic [PAYLOAD_BITS-1:0] out_pay_q;

  assign scan_issue = cmd_i.scan_run && (scan_q != wp_q);
  assign rd_en      = cmd_i.head_rd || scan_issue;
  assign rd_addr    = cmd_i.head_rd ? rp_q : scan_q;
  assign match      = cmd_i.scan_run && chk_q && (rd_cmd_q == cmd_q);
  assign out_free   = !out_valid_q || out_ready_i;

  assign stat_o.func       = func_q;
  assign stat_o.scan_done  = (scan_q == wp_q) && !chk_q;
  assign stat_o.empty      = (rp_q == wp_q);
  assign stat_o.full       = (nxt_slot(wp_q) == rp_q);
  assign stat_o.head_valid = valid_q[rp_q];
  assign stat_o.out_free   = out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q        <= '0;
      wp_q        <= '0;
      scan_q      <= '0;
      chk_q       <= 1'b0;
      valid_q     <= '0;
      func_q      <= FUNC_NOP;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        func_q <= in_func_i;
      end
      if (cmd_i.scan_start) begin
        scan_q <= rp_q;
        chk_q  <= 1'b0;
      end else if (cmd_i.scan_run) begin
        chk_q <= scan_issue;
        if (scan_issue) begin
          scan_q <= nxt_slot(scan_q);
        end
      end
      if (match) begin
        valid_q[chk_ptr_q] <= 1'b0;
      end
      if (cmd_i.push_wr) begin
        valid_q[wp_q] <= 1'b1;
        wp_q          <= nxt_slot(wp_q);
      end
      if (cmd_i.skip_adv || cmd_i.pop_adv) begin
        rp_q <= nxt_slot(rp_q);
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q <= in_cmd_id_i;
      pay_q <= in_payload_i;
    end
    if (cmd_i.push_wr) begin
      cmd_mem[wp_q]  <= cmd_q;
      data_mem[wp_q] <= pay_q;
    end
    if (rd_en) begin
      rd_cmd_q  <= cmd_mem[rd_addr];
      rd_data_q <= data_mem[rd_addr];
    end
    if (scan_issue) begin
      chk_ptr_q <= scan_q;
    end
    if (cmd_i.emit) begin
      out_status_q <= cmd_i.res;
      out_cmd_q    <= cmd_i.res_head ? rd_cmd_q : '0;
      out_pay_q    <= cmd_i.res_head ? rd_data_q : '0;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_status_o       = out_status_q;
  assign out_head_cmd_o     = out_cmd_q;
  assign out_head_payload_o = out_pay_q;

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push_wr |-> !stat_o.full)
    else $error("push stored into a full ring");

  a_head_rd_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.head_rd |-> (!stat_o.empty && valid_q[rp_q]))
    else $error("head read of an empty or invalid slot");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> out_free)
    else $error("result overwritten before transfer");

  a_pop_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.head_rd |=> (rp_q == $past(rp_q)))
    else $error("head moved between read and result");

endmodule

`default_nettype wire

// ===== rtl/ddrf_ctrl.sv =====
`default_nettype none

module ddrf_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  ddrf_pkg::ddrf_func_e in_func_i,
  output logic                 in_ready_o,
  input  ddrf_pkg::ddrf_stat_t stat_i,
  output ddrf_pkg::ddrf_cmd_t  cmd_o
);
  import ddrf_pkg::*;

  ddrf_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = (state_q == S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          case (in_func_i)
            FUNC_PUSH: begin
              cmd_o.scan_start = 1'b1;
              state_d          = S_SCAN;
            end
            FUNC_PEEK, FUNC_POP: state_d = S_SKIP;
            default:             state_d = S_NOP;
          endcase
        end
      end
      S_SCAN: begin
        cmd_o.scan_run = 1'b1;
        if (stat_i.scan_done) begin
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        if (stat_i.out_free) begin
          cmd_o.emit    = 1'b1;
          cmd_o.res     = stat_i.full ? STAT_FULL : STAT_OK;
          cmd_o.push_wr = !stat_i.full;
          state_d       = S_IDLE;
        end
      end
      S_SKIP: begin
        if (stat_i.empty) begin
          state_d = S_EMPTY;
        end else if (stat_i.head_valid) begin
          cmd_o.head_rd = 1'b1;
          state_d       = S_HEAD;
        end else begin
          cmd_o.skip_adv = 1'b1;
        end
      end
      S_HEAD: begin
        if (stat_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.res      = STAT_OK;
          cmd_o.res_head = 1'b1;
          cmd_o.pop_adv  = (stat_i.func == FUNC_POP);
          state_d        = S_IDLE;
        end
      end
      S_EMPTY: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.res  = STAT_EMPTY;
          state_d    = S_IDLE;
        end
      end
      S_NOP: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.res  = STAT_OK;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  a_ready_idle_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ready_o && in_valid_i) |=> (state_q != S_IDLE))
    else $error("accepted transfer left controller idle");

  a_emit_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> (state_q == S_IDLE))
    else $error("result issued without returning idle");

  a_single_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({cmd_o.skip_adv, cmd_o.pop_adv, cmd_o.push_wr}) <= 1)
    else $error("pointer commands overlap");

endmodule

`default_nettype wire

// ===== rtl/dedup_ring_fifo_unit.sv =====
// Command ring FIFO with invalidation of duplicate command ids.
// in_i carries one operation per transfer: func push, peek head or pop head,
// with cmd_id and payload used by push. out_o returns one result per
// operation: status (ok, full, empty), head_cmd and head_payload.
// A push walks the pending entries one per cycle through the command
// memory read port, clearing the valid bit of every entry with the same
// id, then stores the new entry unless the ring is full. Peek and pop
// step the head past invalid entries one per cycle, then read the head
// from memory, or report empty when no valid entry remains. Operations
// are processed one at a time; in_i is ready only while no operation
// is in progress.
// Results sit in an output register; a new operation is accepted while a
// result waits, and the next result holds its final step until out_o is
// free. Reset clears both pointers and all valid bits at once; memory
// contents are not reset, and the block is ready in the first cycle.
`default_nettype none

module dedup_ring_fifo_unit #(
  parameter int DEPTH        = ddrf_pkg::DepthDef,
  parameter int CMD_BITS     = ddrf_pkg::CmdBitsDef,
  parameter int PAYLOAD_BITS = ddrf_pkg::PayloadBitsDef
) (
  input logic        clk_i,
  input logic        rst_ni,
  ddrf_in_if.sink    in_i,
  ddrf_out_if.source out_o
);
  import ddrf_pkg::*;

  ddrf_cmd_t  cmd;
  ddrf_stat_t stat;
  ddrf_func_e in_func;
  logic       in_ready;

  assign in_func    = ddrf_func_e'(in_i.func);
  assign in_i.ready = in_ready;

  ddrf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_func_i  (in_func),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ddrf_datapath #(
    .DEPTH        (DEPTH),
    .CMD_BITS     (CMD_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_func_i          (in_func),
    .in_cmd_id_i        (in_i.cmd_id),
    .in_payload_i       (in_i.payload),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .out_ready_i        (out_o.ready),
    .out_valid_o        (out_o.valid),
    .out_status_o       (out_o.status),
    .out_head_cmd_o     (out_o.head_cmd),
    .out_head_payload_o (out_o.head_payload)
  );

endmodule

`default_nettype wire

// ===== test/ddrf_reply_check.sv =====
`timescale 1ns / 1ps

module ddrf_reply_check (
  input  logic clk_i,
  input  logic rst_ni,
  ddrf_in_if   in_ch,
  ddrf_out_if  out_ch,
  output int   err_count_o,
  output int   pending_o
);
  import ddrf_pkg::*;

  localparam int PtrBits = $clog2(DepthDef);

  typedef logic [PtrBits-1:0] ptr_t;

  typedef struct {
    ddrf_status_e            status;
    logic [CmdBitsDef-1:0]     cmd;
    logic [PayloadBitsDef-1:0] data;
  } fifo_reply_t;

  ptr_t                      head_ptr;
  ptr_t                      tail_ptr;
  logic                      slot_live [DepthDef];
  logic [CmdBitsDef-1:0]     slot_cmd  [DepthDef];
  logic [PayloadBitsDef-1:0] slot_data [DepthDef];
  fifo_reply_t               reply_q [$];

  function automatic fifo_reply_t apply_op(ddrf_func_e op, logic [CmdBitsDef-1:0] cmd,
                                           logic [PayloadBitsDef-1:0] data);
    fifo_reply_t r;
    ptr_t        p;
    r = '{STAT_OK, '0, '0};
    case (op)
      FUNC_PUSH: begin
        p = head_ptr;
        while (p != tail_ptr) begin
          if (slot_cmd[p] == cmd) slot_live[p] = 1'b0;
          p = ptr_t'(p + 1'b1);
        end
        if (ptr_t'(tail_ptr + 1'b1) == head_ptr) begin
          r.status = STAT_FULL;
        end else begin
          slot_cmd[tail_ptr]  = cmd;
          slot_data[tail_ptr] = data;
          slot_live[tail_ptr] = 1'b1;
          tail_ptr = ptr_t'(tail_ptr + 1'b1);
        end
      end
      FUNC_PEEK, FUNC_POP: begin
        while (head_ptr != tail_ptr && !slot_live[head_ptr]) head_ptr = ptr_t'(head_ptr + 1'b1);
        if (head_ptr == tail_ptr) begin
          r.status = STAT_EMPTY;
        end else begin
          r.cmd  = slot_cmd[head_ptr];
          r.data = slot_data[head_ptr];
          if (op == FUNC_POP) head_ptr = ptr_t'(head_ptr + 1'b1);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    fifo_reply_t want;
    if (!rst_ni) begin
      head_ptr = '0;
      tail_ptr = '0;
      for (int i = 0; i < DepthDef; i++) begin
        slot_live[i] = 1'b0;
        slot_cmd[i]  = '0;
        slot_data[i] = '0;
      end
      reply_q.delete();
      err_count_o = 0;
      pending_o   = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (reply_q.size() == 0) begin
          if (err_count_o < 10)
            $display("%0t: unexpected result status=%0d cmd=%02h data=%08h", $realtime,
                     out_ch.status, out_ch.head_cmd, out_ch.head_payload);
          err_count_o++;
        end else begin
          want = reply_q.pop_front();
          if (out_ch.status !== want.status || out_ch.head_cmd !== want.cmd ||
              out_ch.head_payload !== want.data) begin
            if (err_count_o < 10)
              $display("%0t: mismatch exp status=%0d cmd=%02h data=%08h, got %0d %02h %08h",
                       $realtime, want.status, want.cmd, want.data, out_ch.status,
                       out_ch.head_cmd, out_ch.head_payload);
            err_count_o++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        reply_q.push_back(apply_op(ddrf_func_e'(in_ch.func), in_ch.cmd_id, in_ch.payload));
      pending_o = reply_q.size();
    end
  end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import ddrf_pkg::*;

  logic clk_i;
  logic rst_ni;
  int   err_count;
  int   pending;

  ddrf_in_if  in_ch ();
  ddrf_out_if out_ch ();

  dedup_ring_fifo_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  ddrf_reply_check u_reply_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .err_count_o (err_count),
    .pending_o   (pending)
  );

  bit send_calm;

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  task automatic send_op(ddrf_func_e op, logic [CmdBitsDef-1:0] cmd,
                         logic [PayloadBitsDef-1:0] data);
    int gap;
    gap = send_calm ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid   = 1'b1;
    in_ch.func    = op;
    in_ch.cmd_id  = cmd;
    in_ch.payload = data;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  initial begin
    int                    mood;
    int                    pool;
    int                    roll;
    int                    push_pct;
    logic [CmdBitsDef-1:0] cmd;
    ddrf_func_e            op;
    rst_ni        = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.func    = FUNC_NOP;
    in_ch.cmd_id  = '0;
    in_ch.payload = '0;
    send_calm     = 1'b0;
    mood          = 0;
    pool          = 0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_op(FUNC_POP, 8'h00, 32'h0);
    send_op(FUNC_PEEK, 8'hff, 32'hffff_ffff);
    send_op(FUNC_NOP, 8'hff, 32'hffff_ffff);
    send_op(FUNC_PUSH, 8'h00, 32'h0000_0000);
    send_op(FUNC_PUSH, 8'hff, 32'hffff_ffff);
    send_op(FUNC_PUSH, 8'hff, 32'h5a5a_a5a5);
    send_op(FUNC_POP, 8'h00, 32'h0);
    send_op(FUNC_PEEK, 8'h00, 32'h0);
    send_op(FUNC_POP, 8'h00, 32'h0);
    send_op(FUNC_POP, 8'h00, 32'h0);
    for (int i = 1; i <= DepthDef - 1; i++) send_op(FUNC_PUSH, 8'(i), $urandom());
    send_op(FUNC_PUSH, 8'd100, 32'hdead_beef);
    send_op(FUNC_PUSH, 8'd3, 32'h1234_5678);

    for (int n = 0; n < 450; n++) begin
      if (n % 24 == 0) begin
        mood      = $urandom_range(0, 2);
        pool      = $urandom_range(0, 2);
        send_calm = ($urandom_range(0, 3) == 0);
      end
      push_pct = (mood == 0) ? 75 : (mood == 1) ? 20 : 45;
      roll = $urandom_range(0, 99);
      if (roll < push_pct) op = FUNC_PUSH;
      else if (roll >= 97) op = FUNC_NOP;
      else if ($urandom_range(0, 2) == 0) op = FUNC_PEEK;
      else op = FUNC_POP;
      case (pool)
        0: cmd = 8'($urandom_range(0, 3));
        1: cmd = 8'($urandom_range(0, 11));
        default: cmd = 8'($urandom_range(0, 255));
      endcase
      send_op(op, cmd, $urandom());
    end
    in_ch.valid = 1'b0;

    wait (pending == 0);
    repeat (40) @(posedge clk_i);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    int gap;
    int taken;
    out_ch.ready = 1'b0;
    taken        = 0;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      if (taken == 120) begin
        gap = 300;
      end else if ((taken / 50) % 3 == 1) begin
        gap = 0;
      end else begin
        gap = $urandom_range(0, 16);
      end
      if (gap > 0) begin
        out_ch.ready = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      taken++;
      @(negedge clk_i);
    end
  end

  initial begin
    #400000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
